>>> rtl/tbla_pkg.sv
// Shared types and constants for the timed block lease allocator.
// No dependencies; imported by the controller, datapath and top level.
package tbla_pkg;

   localparam int TIME_W    = 32;
   localparam int BLK_W     = 10;
   localparam int TIMEOUT_W = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd600;

   // result status codes
   localparam logic [1:0] STAT_GRANTED = 2'd0;
   localparam logic [1:0] STAT_HIT     = 2'd1;
   localparam logic [1:0] STAT_MISS    = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic clr_wr;    // clearing pass write
      logic capture;   // take the request, issue first read
      logic acc_chk;   // evaluate an access
      logic scan_chk;  // evaluate one block of an allocate scan
      logic out_load;  // move pending result into the output register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic is_access;
      logic in_range;
      logic live;
      logic chk_last;
   } dp_stat_type;

endpackage

>>> rtl/tbla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbla_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tbla_dp.sv
// Datapath: lease table RAM, timeout register, scan counter, result registers.
// Depends on tbla_pkg and tbla_ram.
module tbla_dp
   import tbla_pkg::*;
#(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic                 req_cmd,
   input  logic [TIME_W-1:0]    req_now,
   input  logic [BLK_W-1:0]     req_blk,
   input  logic                 csr_wr,
   input  logic [TIMEOUT_W-1:0] csr_value,
   output logic [1:0]           rsp_status,
   output logic [BLK_W-1:0]     rsp_block
);

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam int RW = TIME_W + 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);

   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]        chk_ff, chk_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [AW-1:0]        blk_ff, blk_in;
   logic [1:0]           pend_status_ff, pend_status_in;
   logic [BLK_W-1:0]     pend_block_ff, pend_block_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [BLK_W-1:0]     rsp_block_ff, rsp_block_in;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [RW-1:0]        ram_wr_data, ram_rd_data;
   logic                 rd_in_use;
   logic [TIME_W-1:0]    rd_last;
   logic [TIME_W-1:0]    age;
   logic                 live;
   logic [31:0]          req_blk_ext;
   logic [AW-1:0]        req_addr;
   logic [AW+BLK_W-1:0]  chk_wide;

   tbla_ram #(
      .WIDTH (RW),
      .DEPTH (NUM_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_in_use   = ram_rd_data[RW-1];
   assign rd_last     = ram_rd_data[TIME_W-1:0];
   assign age         = now_ff - rd_last;
   assign live        = rd_in_use && (age < {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_ff});
   assign req_blk_ext = 32'(req_blk);
   assign req_addr    = req_blk_ext[AW-1:0];
   assign chk_wide    = {{BLK_W{1'b0}}, chk_ff};

   assign stat.clr_last  = (clr_cnt_ff == LAST_IDX);
   assign stat.is_access = req_cmd;
   assign stat.in_range  = (req_blk_ext < 32'(NUM_BLOCKS));
   assign stat.live      = live;
   assign stat.chk_last  = (chk_ff == LAST_IDX);

   // read address: first read at capture, then one block ahead during the scan
   always_comb begin
      if (cmd.capture) begin
         ram_rd_addr = req_cmd ? req_addr : '0;
      end else begin
         ram_rd_addr = chk_ff + AW'(1);
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_cnt_ff;
      ram_wr_data = '0;
      if (cmd.clr_wr) begin
         ram_wr_en = 1'b1;
      end else if (cmd.acc_chk) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = blk_ff;
         ram_wr_data = live ? {1'b1, now_ff} : {1'b0, rd_last};
      end else if (cmd.scan_chk && !live) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = chk_ff;
         ram_wr_data = {1'b1, now_ff};
      end
   end

   always_comb begin
      timeout_in     = csr_wr ? csr_value : timeout_ff;
      clr_cnt_in     = cmd.clr_wr ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
      chk_in         = chk_ff;
      now_in         = now_ff;
      blk_in         = blk_ff;
      pend_status_in = pend_status_ff;
      pend_block_in  = pend_block_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_block_in   = rsp_block_ff;

      if (cmd.capture) begin
         chk_in = '0;
         now_in = req_now;
         blk_in = req_addr;
         // out-of-pool access answers at once
         pend_status_in = STAT_MISS;
         pend_block_in  = '0;
      end
      if (cmd.acc_chk) begin
         pend_status_in = live ? STAT_HIT : STAT_MISS;
         pend_block_in  = '0;
      end
      if (cmd.scan_chk) begin
         chk_in = chk_ff + AW'(1);
         if (!live) begin
            pend_status_in = STAT_GRANTED;
            pend_block_in  = chk_wide[BLK_W-1:0];
         end else begin
            pend_status_in = STAT_FULL;
            pend_block_in  = '0;
         end
      end
      if (cmd.out_load) begin
         rsp_status_in = pend_status_ff;
         rsp_block_in  = pend_block_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         clr_cnt_ff <= '0;
      end else begin
         timeout_ff <= timeout_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff         <= chk_in;
      now_ff         <= now_in;
      blk_ff         <= blk_in;
      pend_status_ff <= pend_status_in;
      pend_block_ff  <= pend_block_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_block_ff   <= rsp_block_in;
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_block  = rsp_block_ff;

endmodule

>>> rtl/tbla_ctrl.sv
// Controller state machine: clearing pass, access check, allocate scan, output.
// Depends on tbla_pkg.
module tbla_ctrl
   import tbla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_ACC   = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (!stat.is_access) begin
                  state_in = S_SCAN;
               end else if (stat.in_range) begin
                  state_in = S_ACC;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_ACC: begin
            cmd.acc_chk = 1'b1;
            state_in    = S_RESP;
         end
         S_SCAN: begin
            cmd.scan_chk = 1'b1;
            if (!stat.live || stat.chk_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/timed_block_lease_allocator_unit.sv
// Timed block lease allocator, top level.
// Depends on tbla_pkg, tbla_ctrl, tbla_dp (and tbla_ram below it).
//
// Usage:
//  - req channel: one item per command. tuser = cmd (0 allocate, 1 access);
//    tdata = now[31:0], block_number[41:32]. Time stamps must not decrease.
//  - rsp channel: exactly one item per request. tuser = status (granted, hit,
//    miss, pool full); tdata = granted_block[9:0], zero unless granted.
//  - csr channel: writes idle_timeout (16 bits, reset 600). Write only while
//    the block is idle; csr_ready is always high.
//  - Access: read on acceptance, then check, then output of the result.
//  - Allocate: the lease RAM is scanned one block a cycle from block 0; the
//    scan stops at the lowest non-live block, which is granted, or after the
//    last block with pool full. The single RAM read port sets the scan rate.
//  - One item in work at a time; the next request is taken the cycle after a
//    result is loaded, even while that result still waits.
//  - Reset: a clearing pass over every block zeroes the in-use bits;
//    req_tready stays low until it ends.
//  - Receiver stall: the result holds in the output register; a following
//    item is worked but waits for the register before it completes.
module timed_block_lease_allocator_unit
   import tbla_pkg::*;
#(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // now[31:0], block_number[41:32], zero pad
   input  logic        req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // granted_block[9:0], zero pad
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // idle_timeout[15:0]
);

   dp_cmd_type      cmd;
   dp_stat_type     stat;
   logic [1:0]      rsp_status;
   logic [BLK_W-1:0] rsp_block;

   assign csr_ready = 1'b1;

   tbla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   tbla_dp #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_cmd    (req_tuser),
      .req_now    (req_tdata[31:0]),
      .req_blk    (req_tdata[41:32]),
      .csr_wr     (csr_valid),
      .csr_value  (csr_data),
      .rsp_status (rsp_status),
      .rsp_block  (rsp_block)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {6'b0, rsp_block};

`ifndef NO_ASSERTIONS
   // the clearing pass keeps the request side closed right after reset
   a_clear_closed: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // one item in work: an accepted request closes the request side
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in work");

   // block number is only reported with a grant
   a_block_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_GRANTED) |-> rsp_tdata == 16'd0)
      else $error("non-zero block number without a grant");

   // the output register only takes a new result once the old one is leaving
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten while stalled");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for timed_block_lease_allocator_unit: directed rows, random items.
// Depends on tbla_pkg and the RTL under rtl/. A local lease model predicts untyped answers.
module tb;
   import tbla_pkg::*;

   localparam int POOL_SIZE      = 1024;
   localparam int RUN_LIMIT      = 8_000_000;   // cycles before the run is abandoned
   localparam int RAND_PER_PHASE = 140;

   localparam logic CMD_ALLOC  = 1'b0;
   localparam logic CMD_ACCESS = 1'b1;

   // idling per random phase: none, sender only, receiver only, both
   localparam int SEND_IDLE [4] = '{0, 56, 0, 37};
   localparam int RECV_IDLE [4] = '{0, 0, 56, 37};
   localparam logic [15:0] PHASE_TMO [3] = '{16'd600, 16'hFFFF, 16'd1};

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic        cmd;
      logic [31:0] now;
      logic [9:0]  blk;
      logic [15:0] timeout;   // CFG rows only
      logic        typed;     // answer typed in below, else predicted
      logic [1:0]  status;
      logic [9:0]  granted;
   } dir_row_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] granted;
   } lease_answer_type;

   typedef struct packed {
      logic             typed;
      lease_answer_type answer;
   } typed_answer_type;

   // Directed rows. Timeout starts at its reset value of 600.
   dir_row_type dir_rows [24] = '{
      '{ROW_ITEM, CMD_ALLOC,  32'd0,         10'd0,    16'd0,     1'b1, STAT_GRANTED, 10'd0},
      '{ROW_ITEM, CMD_ALLOC,  32'd0,         10'd1023, 16'd0,     1'b1, STAT_GRANTED, 10'd1},
      // age one below the timeout still hits
      '{ROW_ITEM, CMD_ACCESS, 32'd599,       10'd0,    16'd0,     1'b1, STAT_HIT,     10'd0},
      // age equal to the timeout misses and frees block 1
      '{ROW_ITEM, CMD_ACCESS, 32'd600,       10'd1,    16'd0,     1'b1, STAT_MISS,    10'd0},
      '{ROW_ITEM, CMD_ALLOC,  32'd600,       10'd0,    16'd0,     1'b1, STAT_GRANTED, 10'd1},
      '{ROW_ITEM, CMD_ACCESS, 32'd600,       10'd1023, 16'd0,     1'b1, STAT_MISS,    10'd0},
      // same expiry rule on allocate: age 600 is free again
      '{ROW_ITEM, CMD_ALLOC,  32'd1199,      10'd0,    16'd0,     1'b1, STAT_GRANTED, 10'd0},
      '{ROW_CFG,  CMD_ALLOC,  32'd0,         10'd0,    16'hFFFF,  1'b0, STAT_GRANTED, 10'd0},
      '{ROW_ITEM, CMD_ALLOC,  32'hFFFF_FFF0, 10'd0,    16'd0,     1'b1, STAT_GRANTED, 10'd0},
      // stamp wraps past zero: age is modulo 2^32
      '{ROW_ITEM, CMD_ACCESS, 32'h0000_0010, 10'd0,    16'd0,     1'b1, STAT_HIT,     10'd0},
      // stamp going backwards looks very old
      '{ROW_ITEM, CMD_ACCESS, 32'h0000_0005, 10'd0,    16'd0,     1'b1, STAT_MISS,    10'd0},
      '{ROW_ITEM, CMD_ALLOC,  32'h0000_0005, 10'd1023, 16'd0,     1'b1, STAT_GRANTED, 10'd0},
      '{ROW_CFG,  CMD_ALLOC,  32'd0,         10'd0,    16'd1,     1'b0, STAT_GRANTED, 10'd0},
      '{ROW_ITEM, CMD_ALLOC,  32'd5,         10'd0,    16'd0,     1'b1, STAT_GRANTED, 10'd1},
      '{ROW_ITEM, CMD_ACCESS, 32'd5,         10'd1,    16'd0,     1'b1, STAT_HIT,     10'd0},
      '{ROW_ITEM, CMD_ACCESS, 32'd6,         10'd1,    16'd0,     1'b1, STAT_MISS,    10'd0},
      // zero timeout: nothing is ever live
      '{ROW_CFG,  CMD_ALLOC,  32'd0,         10'd0,    16'd0,     1'b0, STAT_GRANTED, 10'd0},
      '{ROW_ITEM, CMD_ALLOC,  32'd6,         10'd0,    16'd0,     1'b1, STAT_GRANTED, 10'd0},
      '{ROW_ITEM, CMD_ACCESS, 32'd6,         10'd0,    16'd0,     1'b1, STAT_MISS,    10'd0},
      '{ROW_CFG,  CMD_ALLOC,  32'd0,         10'd0,    16'd600,   1'b0, STAT_GRANTED, 10'd0},
      '{ROW_ITEM, CMD_ALLOC,  32'hFFFF_FFFF, 10'd0,    16'd0,     1'b1, STAT_GRANTED, 10'd0},
      '{ROW_ITEM, CMD_ACCESS, 32'hFFFF_FFFF, 10'd1023, 16'd0,     1'b1, STAT_MISS,    10'd0},
      '{ROW_ITEM, CMD_ALLOC,  32'hFFFF_FFFF, 10'd0,    16'd0,     1'b0, STAT_GRANTED, 10'd0},
      '{ROW_ITEM, CMD_ACCESS, 32'hFFFF_FFFF, 10'd0,    16'd0,     1'b0, STAT_GRANTED, 10'd0}
   };

   // ---------------------------------------------------------------- DUT ports
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;    // now[31:0], block_number[41:32], zero pad
   logic        req_tuser  = 1'b0;  // cmd[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;          // granted_block[9:0], zero pad
   logic [1:0]  rsp_tuser;          // status[1:0]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;    // idle_timeout[15:0]

   // ---------------------------------------------------------- lease model state
   logic        lease_busy  [POOL_SIZE] = '{default: 1'b0};
   logic [31:0] lease_stamp [POOL_SIZE];
   logic [15:0] lease_timeout = TIMEOUT_RST;

   lease_answer_type pending_answers [$];   // answers still owed by the block, oldest first
   typed_answer_type typed_answers   [$];   // per item sent: typed-in answer, if any

   int items_sent    = 0;   // counted by the driver
   int answers_seen  = 0;   // counted by the checker
   int errors        = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   logic [31:0] cur_now = '0;

   timed_block_lease_allocator_unit #(
      .NUM_BLOCKS(POOL_SIZE)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver back-pressure, drawn fresh every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // A block is live while leased and younger than the timeout; age wraps mod 2^32.
   function automatic logic lease_live(input int b, input logic [31:0] now);
      logic [31:0] age;
      age = now - lease_stamp[b];
      return lease_busy[b] && (age < {16'd0, lease_timeout});
   endfunction

   // Applies one item to the lease state and returns the answer it gives.
   function automatic lease_answer_type lease_predict(input logic cmd, input logic [31:0] now,
                                                      input logic [9:0] blk);
      lease_answer_type ans;
      ans.status  = STAT_FULL;
      ans.granted = '0;
      if (cmd == CMD_ALLOC) begin
         // lowest block that is not live wins; none means pool full
         for (int b = 0; b < POOL_SIZE; b++) begin
            if (!lease_live(b, now)) begin
               lease_busy[b]  = 1'b1;
               lease_stamp[b] = now;
               ans.status     = STAT_GRANTED;
               ans.granted    = 10'(b);
               break;
            end
         end
      end else if (lease_live(int'(blk), now)) begin
         lease_stamp[blk] = now;
         ans.status       = STAT_HIT;
      end else begin
         // a miss frees the block
         lease_busy[blk] = 1'b0;
         ans.status      = STAT_MISS;
      end
      return ans;
   endfunction

   // Checker: samples handshakes at the edge, predicts on request, compares on answer.
   always @(posedge clock) begin : lease_watch
      lease_answer_type want;
      lease_answer_type calc;
      typed_answer_type hint;
      if (!reset) begin
         if (csr_valid && csr_ready)
            lease_timeout = csr_data;
         // answer first: one can never belong to the item taken on the same edge
         if (rsp_tvalid && rsp_tready) begin
            answers_seen = answers_seen + 1;
            if (pending_answers.size() == 0) begin
               errors = errors + 1;
               $display("%0t: unexpected answer status %0d tdata %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tuser !== want.status) begin
                  errors = errors + 1;
                  $display("%0t: status mismatch: expected %0d, got %0d",
                           $time, want.status, rsp_tuser);
               end
               if (rsp_tdata !== {6'd0, want.granted}) begin
                  errors = errors + 1;
                  $display("%0t: granted block mismatch: expected %h, got %h",
                           $time, {6'd0, want.granted}, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            calc = lease_predict(req_tuser, req_tdata[31:0], req_tdata[41:32]);
            hint = typed_answers.pop_front();
            pending_answers.push_back(hint.typed ? hint.answer : calc);
         end
      end
   end

   // Presents one request item, after random sender idle cycles, and waits for it to be taken.
   // tvalid is left high so the next item can follow without a bubble.
   task automatic send_item(input logic cmd, input logic [31:0] now, input logic [9:0] blk,
                            input typed_answer_type hint);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      typed_answers.push_back(hint);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, blk, now};
      do @(posedge clock); while (!req_tready);
      items_sent = items_sent + 1;
   endtask

   // Drops the request and waits until every answer owed has come back.
   // The checker may lag the driver, which only makes this wait longer.
   task automatic wait_idle;
      req_tvalid <= 1'b0;
      while (answers_seen != items_sent) @(posedge clock);
   endtask

   // Timeout write, only with the block idle. Never called twice in a row.
   task automatic write_timeout(input logic [15:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      typed_answer_type hint;
      typed_answer_type none;
      logic [15:0]   tmo;
      logic [31:0]   span;
      logic          cmd;
      logic [9:0]    blk;
      int            r;
      none = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed rows
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            write_timeout(dir_rows[i].timeout);
         end else begin
            hint.typed          = dir_rows[i].typed;
            hint.answer.status  = dir_rows[i].status;
            hint.answer.granted = dir_rows[i].granted;
            send_item(dir_rows[i].cmd, dir_rows[i].now, dir_rows[i].blk, hint);
         end
      end

      // --- random phases, one idling pattern and one timeout each
      for (int p = 0; p < 4; p++) begin
         tmo = (p == 3) ? 16'($urandom_range(1, 65535)) : PHASE_TMO[p];
         write_timeout(tmo);
         send_idle_pct = SEND_IDLE[p];
         stall_pct     = RECV_IDLE[p];
         if (p == 1)
            cur_now = 32'hFFFF_8000;   // walk across the stamp wrap
         span = 32'(tmo >> 3) + 32'd1;
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            r = $urandom_range(99);
            if (r < 3)
               cur_now = $urandom();   // any stamp, backwards included
            else if (r < 9)
               cur_now = cur_now + tmo + $urandom_range(0, tmo);   // let leases lapse
            else
               cur_now = cur_now + $urandom_range(0, span);
            cmd = ($urandom_range(99) < 45) ? CMD_ALLOC : CMD_ACCESS;
            // accesses mostly aim at the low blocks, where leases actually sit
            blk = ($urandom_range(99) < 85) ? 10'($urandom_range(0, 31))
                                            : 10'($urandom_range(0, 1023));
            send_item(cmd, cur_now, blk, none);
         end
      end

      // --- drain
      wait_idle();
      stall_pct = 0;
      repeat (16) @(posedge clock);
      if (pending_answers.size() != 0) begin
         errors = errors + 1;
         $display("%0t: %0d answers never arrived", $time, pending_answers.size());
      end
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/tbla_pkg.sv
rtl/tbla_ram.sv
rtl/tbla_dp.sv
rtl/tbla_ctrl.sv
rtl/timed_block_lease_allocator_unit.sv
sim/tb.sv
